// File: hdl/icr_pkg.sv
// Package for the 2-D impulse collision resolver: constants, stage indexes and types.
// Used by icr_sqrt, icr_div and impulse_collision_resolve_2d; depends on nothing.
`default_nettype none
package icr_pkg;

   localparam int MAX_CONTACTS = 2;
   localparam int ONE_Q16      = 65536;
   localparam int SHARE_BITS   = 24;
   localparam int UNIT_BITS    = 30;

   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 32;

   // Pipeline positions of the stage registers in the top level.
   localparam int P_SQRT_IN = 5;
   localparam int P_ROOT    = P_SQRT_IN + SQRT_STAGES;
   localparam int P_QUO     = P_ROOT + DIV_STAGES;
   localparam int P_U       = P_QUO + 1;
   localparam int P_PROD    = P_U + 1;
   localparam int P_DOT     = P_PROD + 1;
   localparam int P_CLOSE   = P_DOT + 1;
   localparam int P_IMPP    = P_CLOSE + 1;
   localparam int P_IMP     = P_IMPP + 1;
   localparam int P_SHARE   = P_IMP + 1;
   localparam int P_CHG     = P_SHARE + 1;
   localparam int P_OUT     = P_CHG + 1;

   typedef enum logic [1:0] {
      OUT_IMPULSE       = 2'd0,
      OUT_SEPARATING    = 2'd1,
      OUT_BOTH_INFINITE = 2'd2
   } outcome_type;

   typedef struct packed {
      logic signed [31:0] vax;
      logic signed [31:0] vay;
      logic signed [31:0] vbx;
      logic signed [31:0] vby;
      logic [31:0]        ma;
      logic [31:0]        mb;
      logic [16:0]        e;
      logic               half;
      logic               nx_neg;
      logic               ny_neg;
      logic               both_inf;
   } item_type;

   typedef struct packed {
      logic [31:0] ax;
      logic [31:0] ay;
      logic        zero;
   } norm_type;

endpackage
`default_nettype wire

// File: hdl/icr_sqrt.sv
// Pipelined integer square root, one result bit per stage, floor of the root.
// Depends on icr_pkg for the stage count.
`default_nettype none
module icr_sqrt (
   input  logic        clock,
   input  logic [63:0] radicand,
   output logic [31:0] root
);
   import icr_pkg::*;

   logic [63:0] rem_ff [SQRT_STAGES];
   logic [63:0] res_ff [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [63:0] BIT_K = 64'd1 << (62 - 2 * k);
      logic [63:0] rem_p, res_p, trial, rem_in, res_in;

      if (k == 0) begin : g_first
         assign rem_p = radicand;
         assign res_p = '0;
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign res_p = res_ff[k-1];
      end

      always_comb begin
         trial = res_p + BIT_K;
         if (rem_p >= trial) begin
            rem_in = rem_p - trial;
            res_in = (res_p >> 1) + BIT_K;
         end else begin
            rem_in = rem_p;
            res_in = res_p >> 1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         res_ff[k] <= res_in;
      end
   end

   assign root = res_ff[SQRT_STAGES-1][31:0];

endmodule
`default_nettype wire

// File: hdl/icr_div.sv
// Pipelined restoring divider, one quotient bit per stage; the quotient must fit 32 bits.
// Depends on icr_pkg for the stage count.
`default_nettype none
module icr_div (
   input  logic        clock,
   input  logic [63:0] num,
   input  logic [32:0] den,
   output logic [31:0] quo
);
   import icr_pkg::*;

   logic [63:0] num_ff [DIV_STAGES];
   logic [32:0] den_ff [DIV_STAGES];
   logic [32:0] rem_ff [DIV_STAGES];
   logic [31:0] quo_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [63:0] num_p;
      logic [32:0] den_p, rem_p, rem_in;
      logic [31:0] quo_p, quo_in;
      logic [33:0] trial;
      logic        ge;

      if (k == 0) begin : g_first
         assign num_p = num;
         assign den_p = den;
         // Dividend upper half seeds the remainder; user must keep it below the divisor.
         assign rem_p = {1'b0, num[63:32]};
         assign quo_p = '0;
      end else begin : g_next
         assign num_p = num_ff[k-1];
         assign den_p = den_ff[k-1];
         assign rem_p = rem_ff[k-1];
         assign quo_p = quo_ff[k-1];
      end

      always_comb begin
         trial  = {rem_p, num_p[DIV_STAGES-1-k]};
         ge     = (trial >= {1'b0, den_p});
         rem_in = ge ? 33'(trial - {1'b0, den_p}) : trial[32:0];
         quo_in = {quo_p[30:0], ge};
      end

      always_ff @(posedge clock) begin
         num_ff[k] <= num_p;
         den_ff[k] <= den_p;
         rem_ff[k] <= rem_in;
         quo_ff[k] <= quo_in;
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: hdl/impulse_collision_resolve_2d.sv
// The result strobe rsp_valid is the valid bit at pipeline position P_OUT.
// Throughput: one item per cycle; busy is held low, the square root and dividers are pipelined.
// The longest section is the square root followed by the normal divider, 32 stages each.
// Reset clears only the valid bits; a reset drops every item still in flight.
// Depends on icr_pkg, icr_sqrt and icr_div.
`default_nettype none
module impulse_collision_resolve_2d (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [31:0]     req_vel_a_x,
   input  logic signed [31:0]     req_vel_a_y,
   input  logic signed [31:0]     req_vel_b_x,
   input  logic signed [31:0]     req_vel_b_y,
   input  logic [31:0]            req_mass_a,
   input  logic [31:0]            req_mass_b,
   input  logic [16:0]            req_restitution_a,
   input  logic [16:0]            req_restitution_b,
   input  logic signed [31:0]     req_normal_x,
   input  logic signed [31:0]     req_normal_y,
   input  logic [1:0]             req_contact_count,
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_new_vel_a_x,
   output logic signed [31:0]     rsp_new_vel_a_y,
   output logic signed [31:0]     rsp_new_vel_b_x,
   output logic signed [31:0]     rsp_new_vel_b_y,
   output icr_pkg::outcome_type   rsp_outcome
);
   import icr_pkg::*;

   function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
      logic signed [31:0] r;
      if (v > 43'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -43'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Left shift that brings the top set bit of m[30:0] to bit 30, or zero if already there or m[30:0] is zero.
   function automatic logic [4:0] norm_shift(input logic [31:0] m);
      logic [4:0] s;
      s = '0;
      for (int i = 0; i < 31; i++) begin
         if (m[i]) begin
            s = 5'(30 - i);
         end
      end
      return s;
   endfunction

   logic [P_OUT:0] vld_ff;
   item_type       itm_ff [P_OUT];
   item_type       itm_in;
   logic [16:0]    e_min;
   logic [1:0]     k_eff;

   logic signed [31:0] nx0_ff, ny0_ff;
   logic [31:0]        ax1_ff, ay1_ff;
   logic [31:0]        ax2_ff, ay2_ff;
   logic [4:0]         sh2_ff;
   logic               zero2_ff;
   norm_type           nrm_ff [3:P_QUO];
   logic [63:0]        sqx4_ff, sqy4_ff, sum5_ff;
   logic [31:0]        root, quo_x, quo_y, quo_a, quo_b;

   logic signed [31:0] ux_ff [P_U:P_CHG];
   logic signed [31:0] uy_ff [P_U:P_CHG];
   logic [24:0]        fa_ff [P_U:P_IMP];
   logic [24:0]        fb_ff [P_U:P_IMP];
   logic signed [64:0] px_ff, py_ff;
   logic signed [65:0] d_ff;
   logic [36:0]        c16_ff;
   logic               sep_ff [P_CLOSE:P_CHG];
   logic [54:0]        impp_ff;
   logic [38:0]        imp_ff;
   logic [63:0]        pa_ff, pb_ff;
   logic [40:0]        cax_ff, cay_ff, cbx_ff, cby_ff;

   logic signed [32:0] rvx, rvy;
   logic signed [66:0] negd;
   logic [17:0]        gain;
   logic [30:0]        mag_ux, mag_uy;
   logic [70:0]        prod_ax, prod_ay, prod_bx, prod_by;
   logic [32:0]        mass_sum;
   item_type           last;
   logic signed [31:0] ux_l, uy_l;

   assign busy = 1'b0;

   // Input conditioning: smaller restitution clamped to one, contact count clamped.
   always_comb begin
      e_min = (req_restitution_a < req_restitution_b) ? req_restitution_a : req_restitution_b;
      if (e_min > 17'(ONE_Q16)) begin
         e_min = 17'(ONE_Q16);
      end
      k_eff = (req_contact_count > 2'(MAX_CONTACTS)) ? 2'(MAX_CONTACTS) : req_contact_count;
      itm_in.vax      = req_vel_a_x;
      itm_in.vay      = req_vel_a_y;
      itm_in.vbx      = req_vel_b_x;
      itm_in.vby      = req_vel_b_y;
      itm_in.ma       = req_mass_a;
      itm_in.mb       = req_mass_b;
      itm_in.e        = e_min;
      itm_in.half     = (k_eff == 2'd2);
      itm_in.nx_neg   = req_normal_x[31];
      itm_in.ny_neg   = req_normal_y[31];
      itm_in.both_inf = (req_mass_a == '0) && (req_mass_b == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[P_OUT-1:0], start & ~busy};
      end
   end

   always_ff @(posedge clock) begin
      itm_ff[0] <= itm_in;
      for (int i = 1; i < P_OUT; i++) begin
         itm_ff[i] <= itm_ff[i-1];
      end
   end

   // Normal conditioning: magnitudes, common scale, squares and their sum.
   always_ff @(posedge clock) begin
      nx0_ff   <= req_normal_x;
      ny0_ff   <= req_normal_y;
      ax1_ff   <= nx0_ff[31] ? 32'(-nx0_ff) : nx0_ff;
      ay1_ff   <= ny0_ff[31] ? 32'(-ny0_ff) : ny0_ff;
      ax2_ff   <= ax1_ff;
      ay2_ff   <= ay1_ff;
      sh2_ff   <= norm_shift((ax1_ff > ay1_ff) ? ax1_ff : ay1_ff);
      zero2_ff <= (ax1_ff == '0) && (ay1_ff == '0);
      nrm_ff[3].ax   <= ax2_ff << sh2_ff;
      nrm_ff[3].ay   <= ay2_ff << sh2_ff;
      nrm_ff[3].zero <= zero2_ff;
      for (int i = 4; i <= P_QUO; i++) begin
         nrm_ff[i] <= nrm_ff[i-1];
      end
      sqx4_ff <= 64'(nrm_ff[3].ax) * 64'(nrm_ff[3].ax);
      sqy4_ff <= 64'(nrm_ff[3].ay) * 64'(nrm_ff[3].ay);
      sum5_ff <= sqx4_ff + sqy4_ff;
   end

   icr_sqrt u_sqrt (
      .clock    (clock),
      .radicand (sum5_ff),
      .root     (root)
   );

   icr_div u_div_ux (
      .clock (clock),
      .num   ({2'b00, nrm_ff[P_ROOT].ax, 30'd0}),
      .den   ({1'b0, root}),
      .quo   (quo_x)
   );

   icr_div u_div_uy (
      .clock (clock),
      .num   ({2'b00, nrm_ff[P_ROOT].ay, 30'd0}),
      .den   ({1'b0, root}),
      .quo   (quo_y)
   );

   // A zero mass gives share zero to itself and the full share to the other body.
   assign mass_sum = {1'b0, itm_ff[P_ROOT].ma} + {1'b0, itm_ff[P_ROOT].mb};

   icr_div u_div_fa (
      .clock (clock),
      .num   ({8'd0, itm_ff[P_ROOT].mb, 24'd0}),
      .den   (mass_sum),
      .quo   (quo_a)
   );

   icr_div u_div_fb (
      .clock (clock),
      .num   ({8'd0, itm_ff[P_ROOT].ma, 24'd0}),
      .den   (mass_sum),
      .quo   (quo_b)
   );

   always_comb begin
      rvx     = 33'(itm_ff[P_U].vbx) - 33'(itm_ff[P_U].vax);
      rvy     = 33'(itm_ff[P_U].vby) - 33'(itm_ff[P_U].vay);
      negd    = 67'sd0 - 67'(d_ff);
      gain    = 18'(ONE_Q16) + 18'(itm_ff[P_CLOSE].e);
      mag_ux  = ux_ff[P_SHARE][31] ? 31'(-ux_ff[P_SHARE]) : ux_ff[P_SHARE][30:0];
      mag_uy  = uy_ff[P_SHARE][31] ? 31'(-uy_ff[P_SHARE]) : uy_ff[P_SHARE][30:0];
      prod_ax = 71'(pa_ff[63:SHARE_BITS]) * 71'(mag_ux);
      prod_ay = 71'(pa_ff[63:SHARE_BITS]) * 71'(mag_uy);
      prod_bx = 71'(pb_ff[63:SHARE_BITS]) * 71'(mag_ux);
      prod_by = 71'(pb_ff[63:SHARE_BITS]) * 71'(mag_uy);
   end

   always_ff @(posedge clock) begin
      ux_ff[P_U] <= nrm_ff[P_QUO].zero ? 32'sd0 :
                    (itm_ff[P_QUO].nx_neg ? 32'(-quo_x) : quo_x);
      uy_ff[P_U] <= nrm_ff[P_QUO].zero ? 32'sd0 :
                    (itm_ff[P_QUO].ny_neg ? 32'(-quo_y) : quo_y);
      fa_ff[P_U] <= (itm_ff[P_QUO].ma == '0) ? 25'd0 :
                    ((itm_ff[P_QUO].mb == '0) ? (25'd1 << SHARE_BITS) : quo_a[24:0]);
      fb_ff[P_U] <= (itm_ff[P_QUO].mb == '0) ? 25'd0 :
                    ((itm_ff[P_QUO].ma == '0) ? (25'd1 << SHARE_BITS) : quo_b[24:0]);
      for (int i = P_U + 1; i <= P_CHG; i++) begin
         ux_ff[i] <= ux_ff[i-1];
         uy_ff[i] <= uy_ff[i-1];
      end
      for (int i = P_U + 1; i <= P_IMP; i++) begin
         fa_ff[i] <= fa_ff[i-1];
         fb_ff[i] <= fb_ff[i-1];
      end
      px_ff <= 65'(rvx) * 65'(ux_ff[P_U]);
      py_ff <= 65'(rvy) * 65'(uy_ff[P_U]);
      d_ff  <= 66'(px_ff) + 66'(py_ff);
      // Closing speed in Q16.16; only used when the bodies approach.
      c16_ff          <= negd[66:UNIT_BITS];
      sep_ff[P_CLOSE] <= (d_ff > 66'sd0);
      for (int i = P_CLOSE + 1; i <= P_CHG; i++) begin
         sep_ff[i] <= sep_ff[i-1];
      end
      impp_ff <= 55'(c16_ff) * 55'(gain);
      imp_ff  <= itm_ff[P_IMPP].half ? 39'(impp_ff >> 17) : impp_ff[54:16];
      pa_ff   <= 64'(imp_ff) * 64'(fa_ff[P_IMP]);
      pb_ff   <= 64'(imp_ff) * 64'(fb_ff[P_IMP]);
      cax_ff  <= prod_ax[70:UNIT_BITS];
      cay_ff  <= prod_ay[70:UNIT_BITS];
      cbx_ff  <= prod_bx[70:UNIT_BITS];
      cby_ff  <= prod_by[70:UNIT_BITS];
   end

   // Body A moves against the unit normal, body B along it.
   always_comb begin
      last = itm_ff[P_CHG];
      ux_l = ux_ff[P_CHG];
      uy_l = uy_ff[P_CHG];
   end

   always_ff @(posedge clock) begin
      if (last.both_inf || sep_ff[P_CHG]) begin
         rsp_new_vel_a_x <= last.vax;
         rsp_new_vel_a_y <= last.vay;
         rsp_new_vel_b_x <= last.vbx;
         rsp_new_vel_b_y <= last.vby;
      end else begin
         rsp_new_vel_a_x <= sat32(ux_l[31] ? 43'(last.vax) + 43'(cax_ff)
                                           : 43'(last.vax) - 43'(cax_ff));
         rsp_new_vel_a_y <= sat32(uy_l[31] ? 43'(last.vay) + 43'(cay_ff)
                                           : 43'(last.vay) - 43'(cay_ff));
         rsp_new_vel_b_x <= sat32(ux_l[31] ? 43'(last.vbx) - 43'(cbx_ff)
                                           : 43'(last.vbx) + 43'(cbx_ff));
         rsp_new_vel_b_y <= sat32(uy_l[31] ? 43'(last.vby) - 43'(cby_ff)
                                           : 43'(last.vby) + 43'(cby_ff));
      end
      if (last.both_inf) begin
         rsp_outcome <= OUT_BOTH_INFINITE;
      end else if (sep_ff[P_CHG]) begin
         rsp_outcome <= OUT_SEPARATING;
      end else begin
         rsp_outcome <= OUT_IMPULSE;
      end
   end

   assign rsp_valid = vld_ff[P_OUT];

endmodule
`default_nettype wire
